// File: rtl/core/asmc_pkg.sv
// Shared types, constants and saturation helpers for the adaptive sliding-mode controller.
package asmc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int WIDE_W = 64;
    localparam int MAG_W  = 63;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 3;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 24;

    localparam logic signed [WIDE_W-1:0] WIDE_LIM = (64'sd1 <<< 62) - 64'sd1;

    typedef enum logic [IDX_W-1:0] {
        REG_STEP_TIME,
        REG_INTEGRAL_WEIGHT,
        REG_SURFACE_GAIN,
        REG_ADAPT_MAIN,
        REG_ADAPT_ROBUST
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_AL_INT,
        ST_TS_SCALE,
        ST_EDOT,
        ST_SIGN,
        ST_KA_OMEGA,
        ST_EDOT_AL,
        ST_ROBUST_OLD,
        ST_D1_TERM,
        ST_KDOT,
        ST_DDOT,
        ST_MG_UPD,
        ST_RG_UPD,
        ST_ROBUST_NEW,
        ST_DRIVE
    } step_t;

    typedef struct packed {
        logic  load;
        logic  start;
        logic  commit;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } sts_t;

    function automatic logic signed [WIDE_W-1:0] clampv(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [WIDE_W-1:0] lo,
        input logic signed [WIDE_W-1:0] hi
    );
        logic signed [WIDE_W-1:0] r;
        r = (v < lo) ? lo : ((v > hi) ? hi : v);
        return r;
    endfunction

    // Operands stay within +-WIDE_LIM, so the raw sum cannot wrap.
    function automatic logic signed [WIDE_W-1:0] sadd(
        input logic signed [WIDE_W-1:0] a,
        input logic signed [WIDE_W-1:0] b
    );
        logic signed [WIDE_W-1:0] s;
        s = a + b;
        return clampv(s, -WIDE_LIM, WIDE_LIM);
    endfunction

endpackage

// File: rtl/core/asmc_muldiv.sv
// Shared sequential fixed-point multiply/divide unit with magnitude saturation.
module asmc_muldiv #(
    parameter int FRAC_BITS = asmc_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic                               op_div,
    input  logic signed [asmc_pkg::WIDE_W-1:0] opa,
    input  logic signed [asmc_pkg::WIDE_W-1:0] opb,
    output logic signed [asmc_pkg::WIDE_W-1:0] result,
    output logic                               done
);
    import asmc_pkg::*;

    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int ACC_W = 2 * WIDE_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} ustate_t;

    ustate_t                    state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       neg_reg;
    logic                       div_reg;
    logic [MAG_W-1:0]           amag_reg;
    logic [MAG_W-1:0]           bmag_reg;
    logic [WIDE_W-1:0]          pp_reg;
    logic [1:0]                 sh_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [NUM_W-1:0]           quot_reg;
    logic [WIDE_W-1:0]          rem_reg;
    logic signed [WIDE_W-1:0]   result_reg;
    logic                       done_reg;

    logic [MAG_W-1:0]           amag_in;
    logic [MAG_W-1:0]           bmag_in;
    logic [31:0]                a_chunk;
    logic [31:0]                b_chunk;
    logic [WIDE_W-1:0]          rem_shift;
    logic                       rem_ge;
    logic                       mul_sat;
    logic                       div_sat;
    logic [WIDE_W-1:0]          mag_fin;

    always_comb begin
        logic signed [WIDE_W-1:0] na;
        logic signed [WIDE_W-1:0] nb;
        na = -opa;
        nb = -opb;
        amag_in = opa[WIDE_W-1] ? na[MAG_W-1:0] : opa[MAG_W-1:0];
        bmag_in = opb[WIDE_W-1] ? nb[MAG_W-1:0] : opb[MAG_W-1:0];
    end

    assign a_chunk   = cnt_reg[1] ? {1'b0, amag_reg[MAG_W-1:32]} : amag_reg[31:0];
    assign b_chunk   = cnt_reg[0] ? {1'b0, bmag_reg[MAG_W-1:32]} : bmag_reg[31:0];
    assign rem_shift = {rem_reg[WIDE_W-2:0], num_reg[NUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, bmag_reg};

    assign mul_sat = |(acc_reg >> (FRAC_BITS + 62));
    assign div_sat = |(quot_reg >> 62);

    always_comb begin
        if (div_reg) begin
            mag_fin = div_sat ? WIDE_LIM : {2'b00, quot_reg[61:0]};
        end else begin
            mag_fin = mul_sat ? WIDE_LIM : {2'b00, acc_reg[FRAC_BITS +: 62]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE: begin
                    if (start) begin
                        amag_reg  <= amag_in;
                        bmag_reg  <= bmag_in;
                        neg_reg   <= opa[WIDE_W-1] ^ opb[WIDE_W-1];
                        div_reg   <= op_div;
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        rem_reg   <= '0;
                        quot_reg  <= '0;
                        num_reg   <= {amag_in, {FRAC_BITS{1'b0}}};
                        state_reg <= op_div ? U_DIV : U_MUL;
                    end
                end
                U_MUL: begin
                    // four 32x32 partial products, each registered and added in the following cycle
                    pp_reg  <= a_chunk * b_chunk;
                    sh_reg  <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_reg + (ACC_W'(pp_reg) << (32 * sh_reg));
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(4)) begin
                        state_reg <= U_FIN;
                    end
                end
                U_DIV: begin
                    // restoring division, one quotient bit per cycle
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    rem_reg  <= rem_ge ? rem_shift - {1'b0, bmag_reg} : rem_shift;
                    quot_reg <= {quot_reg[NUM_W-2:0], rem_ge};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                        state_reg <= U_FIN;
                    end
                end
                U_FIN: begin
                    result_reg <= neg_reg ? -$signed(mag_fin) : $signed(mag_fin);
                    done_reg   <= 1'b1;
                    state_reg  <= U_IDLE;
                end
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// File: rtl/core/asmc_datapath.sv
// Datapath: configuration, controller state, step operand selection and result stage.
module asmc_datapath #(
    parameter int DATA_WIDTH = asmc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = asmc_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [asmc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [asmc_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic signed [asmc_pkg::IN_W-1:0]  s_desired,
    input  logic signed [asmc_pkg::IN_W-1:0]  s_measured,
    input  logic                              s_restart,
    input  asmc_pkg::cmd_t                    cmd,
    output asmc_pkg::sts_t                    sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [asmc_pkg::OUT_W-1:0] m_drive
);
    import asmc_pkg::*;

    localparam int INT_W = FRAC_BITS + 14;
    localparam logic signed [WIDE_W-1:0] EPS_Q   = ((64'sd1 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam logic signed [WIDE_W-1:0] INT_LIM = 64'sd5000 <<< FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] OUT_LIM = 64'sd120 <<< FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] DW_MAX  = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [WIDE_W-1:0] DW_MIN  = -(64'sd1 <<< (DATA_WIDTH - 1));

    logic [CFG_W-1:0] step_time_reg;
    logic [CFG_W-1:0] integral_weight_reg;
    logic [CFG_W-1:0] surface_gain_reg;
    logic [CFG_W-1:0] adapt_main_reg;
    logic [CFG_W-1:0] adapt_robust_reg;

    logic signed [DATA_WIDTH-1:0] last_error_reg;
    logic signed [INT_W-1:0]      integral_reg;
    logic signed [DATA_WIDTH-1:0] main_gain_reg;
    logic signed [DATA_WIDTH-1:0] robust_gain_reg;

    logic signed [DATA_WIDTH-1:0] err_reg;
    logic signed [IN_W-1:0]       des_reg;
    logic signed [WIDE_W-1:0]     diff_reg;
    logic signed [WIDE_W-1:0]     t_reg;
    logic signed [WIDE_W-1:0]     omega_reg;
    logic signed [WIDE_W-1:0]     edot_reg;
    logic signed [WIDE_W-1:0]     sg_reg;
    logic signed [WIDE_W-1:0]     base_reg;
    logic signed [WIDE_W-1:0]     term_reg;
    logic signed [WIDE_W-1:0]     kdot_reg;
    logic signed [WIDE_W-1:0]     ddot_reg;
    logic signed [OUT_W-1:0]      drive_reg;
    logic                         m_valid_reg;

    logic signed [WIDE_W-1:0] ts_w, al_w, ka_w, d1_w, d2_w;
    logic signed [WIDE_W-1:0] err_w, des_w, mg_w, rg_w;
    logic signed [WIDE_W-1:0] opa, opb, res;
    logic signed [WIDE_W-1:0] omega_mag;
    logic                     op_div;
    logic                     unit_done;

    logic signed [WIDE_W-1:0] e_next;
    logic signed [WIDE_W-1:0] int_next;
    logic signed [WIDE_W-1:0] last_w;
    logic signed [WIDE_W-1:0] int_w;
    logic signed [WIDE_W-1:0] gain_next;
    logic signed [WIDE_W-1:0] drive_next;

    assign ts_w  = WIDE_W'(step_time_reg);
    assign al_w  = WIDE_W'(integral_weight_reg);
    assign ka_w  = WIDE_W'(surface_gain_reg);
    assign d1_w  = WIDE_W'(adapt_main_reg);
    assign d2_w  = WIDE_W'(adapt_robust_reg);
    assign err_w = WIDE_W'(err_reg);
    assign des_w = WIDE_W'(des_reg);
    assign mg_w  = WIDE_W'(main_gain_reg);
    assign rg_w  = WIDE_W'(robust_gain_reg);
    assign omega_mag = (omega_reg[WIDE_W-1] ? -omega_reg : omega_reg) + EPS_Q;

    // Error and clamped integral for the incoming sample; restart drops history.
    always_comb begin
        last_w   = s_restart ? '0 : WIDE_W'(last_error_reg);
        int_w    = s_restart ? '0 : WIDE_W'(integral_reg);
        e_next   = clampv(WIDE_W'(s_desired) - WIDE_W'(s_measured), DW_MIN, DW_MAX);
        int_next = clampv(int_w + e_next, -INT_LIM, INT_LIM);
    end

    always_comb begin
        op_div = 1'b0;
        opa    = al_w;
        opb    = WIDE_W'(integral_reg);
        case (cmd.step)
            ST_AL_INT:     begin opa = al_w;     opb = WIDE_W'(integral_reg); end
            ST_TS_SCALE:   begin opa = t_reg;    opb = ts_w;      end
            ST_EDOT:       begin opa = diff_reg; opb = ts_w;      op_div = 1'b1; end
            ST_SIGN:       begin opa = omega_reg; opb = omega_mag; op_div = 1'b1; end
            ST_KA_OMEGA:   begin opa = ka_w;     opb = omega_reg; end
            ST_EDOT_AL:    begin opa = edot_reg; opb = al_w;      op_div = 1'b1; end
            ST_ROBUST_OLD: begin opa = sg_reg;   opb = rg_w;      end
            ST_D1_TERM:    begin opa = d1_w;     opb = term_reg;  end
            ST_KDOT:       begin opa = t_reg;    opb = omega_reg; end
            ST_DDOT:       begin opa = d2_w;     opb = sg_reg;    end
            ST_MG_UPD:     begin opa = kdot_reg; opb = ts_w;      end
            ST_RG_UPD:     begin opa = ddot_reg; opb = ts_w;      end
            ST_ROBUST_NEW: begin opa = sg_reg;   opb = rg_w;      end
            ST_DRIVE:      begin opa = mg_w;     opb = term_reg;  end
            default:       begin opa = al_w;     opb = ts_w;      end
        endcase
    end

    asmc_muldiv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .op_div  (op_div),
        .opa     (opa),
        .opb     (opb),
        .result  (res),
        .done    (unit_done)
    );

    always_comb begin
        gain_next  = clampv(sadd(cmd.step == ST_MG_UPD ? mg_w : rg_w, res), DW_MIN, DW_MAX);
        drive_next = clampv(res, -OUT_LIM, OUT_LIM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg       <= CFG_W'(EPS_Q);
            integral_weight_reg <= CFG_W'(64'sd5 <<< FRAC_BITS);
            surface_gain_reg    <= CFG_W'(64'sd15 <<< FRAC_BITS);
            adapt_main_reg      <= CFG_W'(64'sd10 <<< FRAC_BITS);
            adapt_robust_reg    <= CFG_W'(64'sd10 <<< FRAC_BITS);
            last_error_reg      <= '0;
            integral_reg        <= '0;
            main_gain_reg       <= '0;
            robust_gain_reg     <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            // zero writes are dropped: every register stays positive
            if (cfg_wr_en && cfg_wdata != '0) begin
                case (cfg_index)
                    REG_STEP_TIME:       step_time_reg       <= cfg_wdata;
                    REG_INTEGRAL_WEIGHT: integral_weight_reg <= cfg_wdata;
                    REG_SURFACE_GAIN:    surface_gain_reg    <= cfg_wdata;
                    REG_ADAPT_MAIN:      adapt_main_reg      <= cfg_wdata;
                    REG_ADAPT_ROBUST:    adapt_robust_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                err_reg        <= DATA_WIDTH'(e_next);
                last_error_reg <= DATA_WIDTH'(e_next);
                integral_reg   <= INT_W'(int_next);
                des_reg        <= s_desired;
                diff_reg       <= e_next - last_w;
            end
            if (cmd.commit && cmd.step == ST_DRIVE) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.commit) begin
                case (cmd.step)
                    ST_AL_INT:     t_reg     <= res;
                    ST_TS_SCALE:   omega_reg <= sadd(err_w, res);
                    ST_EDOT:       edot_reg  <= res;
                    ST_SIGN:       sg_reg    <= res;
                    ST_KA_OMEGA:   base_reg  <= sadd(res, des_w);
                    ST_EDOT_AL:    base_reg  <= sadd(base_reg, res);
                    ST_ROBUST_OLD: term_reg  <= sadd(base_reg, res);
                    ST_D1_TERM:    t_reg     <= res;
                    ST_KDOT:       kdot_reg  <= res;
                    ST_DDOT:       ddot_reg  <= res;
                    ST_MG_UPD:     main_gain_reg   <= DATA_WIDTH'(gain_next);
                    ST_RG_UPD:     robust_gain_reg <= DATA_WIDTH'(gain_next);
                    ST_ROBUST_NEW: term_reg  <= sadd(base_reg, res);
                    ST_DRIVE:      drive_reg <= OUT_W'(drive_next);
                    default: ;
                endcase
            end
        end
    end

    assign sts.done     = unit_done;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_drive      = drive_reg;

endmodule

// File: rtl/core/asmc_ctrl.sv
// Controller: sequences the per-sample steps through the shared arithmetic unit.
module asmc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  asmc_pkg::sts_t sts,
    output asmc_pkg::cmd_t cmd
);
    import asmc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_COMMIT} state_t;

    state_t state_reg;
    step_t  step_reg;
    logic   commit_ok;

    // the final step may only land when the result register is free
    assign commit_ok = (step_reg != ST_DRIVE) || sts.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= ST_AL_INT;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        step_reg  <= ST_AL_INT;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (sts.done) begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (commit_ok) begin
                        if (step_reg == ST_DRIVE) begin
                            state_reg <= S_IDLE;
                        end else begin
                            step_reg  <= step_t'(step_reg + 1'b1);
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && s_valid;
    assign cmd.start  = (state_reg == S_ISSUE);
    assign cmd.commit = (state_reg == S_COMMIT) && commit_ok;
    assign cmd.step   = step_reg;

endmodule

// File: rtl/core/adaptive_sliding_mode_controller_core.sv
// Top level of the adaptive sliding-mode controller: controller plus datapath.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid/s_ready   | s_desired, s_measured, s_restart
//  m_      | out       | m_valid/m_ready   | m_drive
//  cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// Each sample runs through the single shared multiply/divide unit: eleven multiplies of
// four 32x32 partial products each, and three divides at one quotient bit a cycle.
// Reset is synchronous, active low; the next sample is taken once the last step
// has moved its drive value into the output register, even while it waits on m_ready.
module adaptive_sliding_mode_controller_core #(
    parameter int DATA_WIDTH = asmc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = asmc_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [asmc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [asmc_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [asmc_pkg::IN_W-1:0]  s_desired,
    input  logic signed [asmc_pkg::IN_W-1:0]  s_measured,
    input  logic                              s_restart,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [asmc_pkg::OUT_W-1:0] m_drive
);
    import asmc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    asmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    asmc_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_desired  (s_desired),
        .s_measured (s_measured),
        .s_restart  (s_restart),
        .cmd        (cmd),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive)
    );

endmodule

// File: rtl/core/asmc_checker.sv
// Port-level checks for the controller core and the bind that attaches them.
module asmc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [asmc_pkg::OUT_W-1:0] m_drive
);

    // result register empties on reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a transfer in occupies the sequencer
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after input transfer");

    // no result can follow an input in the next cycle
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after input");

    // hold a stalled result
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive))
        else $error("stalled result changed or dropped");

endmodule

bind adaptive_sliding_mode_controller_core asmc_checker u_asmc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_drive (m_drive)
);
